@@ rtl/core/counting_bloom_filter_core_assert.svh @@
// assertion helpers, sampled on clk and disabled during rst
`ifndef COUNTING_BLOOM_FILTER_CORE_ASSERT_SVH
`define COUNTING_BLOOM_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define CBF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/cbf_pkg.sv @@
package cbf_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COUNTER_MAX_DEF = 15;
  localparam int MAX_HASHES_DEF  = 20;

  localparam logic [12:0] TS_RESET = 13'd4096;
  localparam logic [4:0]  NH_RESET = 5'd7;
  localparam int          TS_MIN   = 64;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'he6546b64;
  localparam logic [31:0] C4 = 32'h85ebca6b;
  localparam logic [31:0] C5 = 32'hc2b2ae35;

  localparam int MIX_STEPS = 6;
  localparam int DIG_BITS  = 4;
  localparam int NUM_DIGS  = 32 / DIG_BITS;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MIX_NONE,
    MIX_MUL1,
    MIX_MUL2,
    MIX_ROUND,
    MIX_MUL4,
    MIX_MUL5,
    MIX_FIN
  } mix_op_t;

  typedef struct packed {
    logic    load;
    mix_op_t mix_op;
    logic    seed_h1;
    logic    latch_h1;
    logic    latch_h2;
    logic    div_step;
    logic    pass_init;
    logic    mem_rd;
    logic    chk_step;
    logic    upd_step;
    logic    clr_step;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_last;
    logic idx_last;
    logic clr_last;
    logic fail;
  } dp_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ rtl/core/cbf_ctrl.sv @@
module cbf_ctrl import cbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_sts_t    sts,
  output dp_cmd_t    dcmd,
  output logic       busy
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_MIX, ST_DIV, ST_CHK_RD, ST_CHK,
    ST_UPD_RD, ST_UPD, ST_CLR, ST_FIN
  } state_t;

  localparam logic [3:0] MIX_LAST = 4'(2 * MIX_STEPS - 1);

  state_t     state, state_next;
  logic [3:0] mix_cnt;
  logic [2:0] stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      mix_cnt <= '0;
    end else begin
      state   <= state_next;
      mix_cnt <= (state == ST_MIX) ? mix_cnt + 4'd1 : 4'd0;
    end
  end

  assign busy  = (state != ST_IDLE);
  assign stage = (mix_cnt >= 4'(MIX_STEPS)) ? 3'(mix_cnt - 4'(MIX_STEPS)) : mix_cnt[2:0];

  always_comb begin
    dcmd       = '0;
    dcmd.mix_op = MIX_NONE;
    state_next = state;
    case (state)
      ST_INIT: begin
        dcmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          dcmd.load  = 1'b1;
          state_next = (op_t'(cmd) == OP_CLEAR) ? ST_CLR : ST_MIX;
        end
      end
      ST_MIX: begin
        case (stage)
          3'd0:    dcmd.mix_op = MIX_MUL1;
          3'd1:    dcmd.mix_op = MIX_MUL2;
          3'd2:    dcmd.mix_op = MIX_ROUND;
          3'd3:    dcmd.mix_op = MIX_MUL4;
          3'd4:    dcmd.mix_op = MIX_MUL5;
          3'd5:    dcmd.mix_op = MIX_FIN;
          default: dcmd.mix_op = MIX_NONE;
        endcase
        dcmd.seed_h1  = (mix_cnt >= 4'(MIX_STEPS));
        dcmd.latch_h1 = (mix_cnt == 4'(MIX_STEPS - 1));
        dcmd.latch_h2 = (mix_cnt == MIX_LAST);
        if (mix_cnt == MIX_LAST) state_next = ST_DIV;
      end
      ST_DIV: begin
        dcmd.div_step = 1'b1;
        if (sts.div_last && sts.idx_last) begin
          dcmd.pass_init = 1'b1;
          state_next = (sts.op == OP_ADD) ? ST_UPD_RD : ST_CHK_RD;
        end
      end
      ST_CHK_RD: begin
        dcmd.mem_rd = 1'b1;
        state_next  = ST_CHK;
      end
      ST_CHK: begin
        dcmd.chk_step = 1'b1;
        if (sts.idx_last) begin
          if (sts.op == OP_REMOVE && !sts.fail) begin
            dcmd.pass_init = 1'b1;
            state_next = ST_UPD_RD;
          end else begin
            state_next = ST_FIN;
          end
        end else begin
          state_next = ST_CHK_RD;
        end
      end
      ST_UPD_RD: begin
        dcmd.mem_rd = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        dcmd.upd_step = 1'b1;
        state_next = sts.idx_last ? ST_FIN : ST_UPD_RD;
      end
      ST_CLR: begin
        dcmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        dcmd.finish = 1'b1;
        state_next  = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

@@ rtl/core/cbf_dp.sv @@
module cbf_dp import cbf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNTER_MAX = COUNTER_MAX_DEF,
  parameter int MAX_HASHES  = MAX_HASHES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            dcmd,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] key,
  input  logic [12:0]        table_size,
  input  logic [4:0]         num_hashes,
  output dp_sts_t            sts,
  output logic               done,
  output logic               ok,
  output logic [30:0]        element_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(COUNTER_MAX + 1);
  localparam int IW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam logic [CW-1:0] CMAX = CW'(COUNTER_MAX);
  localparam logic [30:0]   ELEM_MAX = '1;

  logic [CW-1:0] mem [TABLE_DEPTH];
  logic [AW-1:0] pos [MAX_HASHES];

  op_t           op;
  logic [31:0]   key_q, hv, hv_next, h1, h2, acc, shr;
  logic [31:0]   seed, t0, t1, t2, acc_next;
  logic [AW-1:0] rem, rem_next, clr_addr, waddr;
  logic [2:0]    dig;
  logic [IW-1:0] idx, klast;
  logic [SW-1:0] eff_s, trial;
  logic [31:0]   s32, k32;
  logic [CW-1:0] rdata, wdata;
  logic          zero_seen, rd_zero, we;
  logic [30:0]   elements;

  // effective table size and hash count
  always_comb begin
    s32 = 32'(table_size);
    if (s32 < 32'(TS_MIN)) s32 = 32'(TS_MIN);
    if (s32 > 32'(TABLE_DEPTH)) s32 = 32'(TABLE_DEPTH);
    k32 = 32'(num_hashes);
    if (k32 < 32'd1) k32 = 32'd1;
    if (k32 > 32'(MAX_HASHES)) k32 = 32'(MAX_HASHES);
  end
  assign eff_s = s32[SW-1:0];
  assign klast = IW'(k32 - 32'd1);

  // one murmur step per cycle, one multiply at most
  assign seed = dcmd.seed_h1 ? h1 : 32'd0;
  always_comb begin
    t0 = rotl32(seed ^ hv, 13);
    t1 = (t0 << 2) + t0 + C3;
    t2 = t1 ^ 32'd4;
    case (dcmd.mix_op)
      MIX_MUL1:  hv_next = key_q * C1;
      MIX_MUL2:  hv_next = rotl32(hv, 15) * C2;
      MIX_ROUND: hv_next = t2 ^ (t2 >> 16);
      MIX_MUL4:  hv_next = hv * C4;
      MIX_MUL5:  hv_next = (hv ^ (hv >> 13)) * C5;
      MIX_FIN:   hv_next = hv ^ (hv >> 16);
      default:   hv_next = hv;
    endcase
  end

  // radix-16 restoring remainder, four bits per cycle
  always_comb begin
    rem_next = rem;
    for (int j = 0; j < DIG_BITS; j++) begin
      trial = {rem_next, shr[31-j]};
      rem_next = (trial >= eff_s) ? AW'(trial - eff_s) : trial[AW-1:0];
    end
  end
  assign acc_next = acc + h2;

  assign rd_zero = (rdata == '0);
  always_comb begin
    if (op == OP_ADD) wdata = (rdata == CMAX) ? rdata : rdata + CW'(1);
    else              wdata = rd_zero ? rdata : rdata - CW'(1);
  end
  assign we    = dcmd.clr_step | dcmd.upd_step;
  assign waddr = dcmd.clr_step ? clr_addr : pos[idx];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= dcmd.clr_step ? '0 : wdata;
    if (dcmd.mem_rd) rdata <= mem[pos[idx]];
  end

  // payload
  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      op    <= op_t'(cmd);
      key_q <= key;
    end
    hv <= hv_next;
    if (dcmd.latch_h1) h1 <= hv_next;
    if (dcmd.latch_h2) begin
      h2  <= hv_next;
      acc <= h1;
      shr <= h1;
      rem <= '0;
    end
    if (dcmd.div_step) begin
      if (dig == 3'(NUM_DIGS - 1)) begin
        pos[idx] <= rem_next;
        acc <= acc_next;
        shr <= acc_next;
        rem <= '0;
      end else begin
        shr <= shr << DIG_BITS;
        rem <= rem_next;
      end
    end
    if (dcmd.finish) begin
      ok <= (op == OP_ADD) || (op == OP_CLEAR) || !zero_seen;
      case (op)
        OP_ADD:    element_count <= (elements == ELEM_MAX) ? elements : elements + 31'd1;
        OP_REMOVE: element_count <= (!zero_seen && elements != '0) ? elements - 31'd1
                                                                     : elements;
        OP_CLEAR:  element_count <= '0;
        default:   element_count <= elements;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      elements  <= '0;
      clr_addr  <= '0;
      dig       <= '0;
      idx       <= '0;
      zero_seen <= 1'b0;
    end else begin
      done <= dcmd.finish;
      if (dcmd.load) begin
        clr_addr  <= '0;
        zero_seen <= 1'b0;
      end
      if (dcmd.clr_step)
        clr_addr <= (clr_addr == AW'(TABLE_DEPTH - 1)) ? '0 : clr_addr + AW'(1);
      if (dcmd.latch_h2) begin
        dig <= '0;
        idx <= '0;
      end
      if (dcmd.div_step) begin
        dig <= (dig == 3'(NUM_DIGS - 1)) ? 3'd0 : dig + 3'd1;
        if (dig == 3'(NUM_DIGS - 1)) idx <= idx + IW'(1);
      end
      if (dcmd.chk_step) begin
        if (rd_zero) zero_seen <= 1'b1;
        idx <= idx + IW'(1);
      end
      if (dcmd.upd_step) idx <= idx + IW'(1);
      if (dcmd.pass_init) idx <= '0;
      if (dcmd.finish) begin
        case (op)
          OP_ADD:    if (elements != ELEM_MAX) elements <= elements + 31'd1;
          OP_REMOVE: if (!zero_seen && elements != '0) elements <= elements - 31'd1;
          OP_CLEAR:  elements <= '0;
          default:   elements <= elements;
        endcase
      end
    end
  end

  assign sts.op       = op;
  assign sts.div_last = (dig == 3'(NUM_DIGS - 1));
  assign sts.idx_last = (idx == klast);
  assign sts.clr_last = (clr_addr == AW'(TABLE_DEPTH - 1));
  assign sts.fail     = zero_seen | rd_zero;

endmodule

@@ rtl/core/counting_bloom_filter_core.sv @@
// channel   signals                                   handshake
// command   start, cmd, key                           beat taken when start && !busy
// result    done, ok, element_count                   beat valid while done is high
// config    psel, penable, pwrite, paddr, pwdata/prdata  write on access cycle
//
// k = effective hash count, S = TABLE_DEPTH.
// every command but clear hashes the key, then reduces k positions with the
// 4-bit-per-cycle remainder unit. add then reads and updates each position;
// lookup and remove read and check all k, and a successful remove then updates
// all k. clear zeroes all S counters; after rst they are swept to zero with busy high.
// done lasts one cycle and cannot be stalled.
module counting_bloom_filter_core import cbf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNTER_MAX = COUNTER_MAX_DEF,
  parameter int MAX_HASHES  = MAX_HASHES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic signed [31:0] key,
  output logic               done,
  output logic               ok,
  output logic [30:0]        element_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "counting_bloom_filter_core_assert.svh"

  logic [12:0] table_size;
  logic [4:0]  num_hashes;
  dp_cmd_t     dcmd;
  dp_sts_t     sts;

  assign pready = 1'b1;

  // word addressed, byte bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TS_RESET;
      num_hashes <= NH_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) num_hashes <= pwdata[4:0];
      else          table_size <= pwdata[12:0];
    end
  end

  assign prdata = paddr[2] ? {27'd0, num_hashes} : {19'd0, table_size};

  cbf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .dcmd  (dcmd),
    .busy  (busy)
  );

  cbf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNTER_MAX (COUNTER_MAX),
    .MAX_HASHES  (MAX_HASHES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dcmd          (dcmd),
    .cmd           (cmd),
    .key           (key),
    .table_size    (table_size),
    .num_hashes    (num_hashes),
    .sts           (sts),
    .done          (done),
    .ok            (ok),
    .element_count (element_count)
  );

  `CBF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `CBF_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without work in flight")
  `CBF_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

endmodule

@@ sim/tb_counting_bloom_filter_core.sv @@
`timescale 1ns / 1ps

module tb_counting_bloom_filter_core;
  import cbf_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CMAX  = COUNTER_MAX_DEF;
  localparam int HMAX  = MAX_HASHES_DEF;
  localparam logic [2:0] ADDR_TABLE_SIZE = 3'd0;
  localparam logic [2:0] ADDR_NUM_HASHES = 3'd4;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic        ok;
    logic [30:0] count;
  } filter_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  op_t                cmd = OP_LOOKUP;
  logic signed [31:0] key = '0;
  logic               done;
  logic               ok;
  logic [30:0]        element_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  logic [3:0]  model_counters [DEPTH];
  logic [30:0] model_elements;
  logic [12:0] model_table_size;
  logic [4:0]  model_num_hashes;

  filter_result_t pending_results[$];
  logic [31:0]    added_keys[$];
  int             errors = 0;
  int             burst_left = 0;

  always #6 clk = ~clk;

  counting_bloom_filter_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .done(done), .ok(ok), .element_count(element_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic logic [31:0] murmur_mix(input logic [31:0] kin, input logic [31:0] seed);
    logic [31:0] k;
    logic [31:0] h;
    k = kin * C1;
    k = {k[16:0], k[31:17]};
    k = k * C2;
    h = seed ^ k;
    h = {h[18:0], h[31:19]};
    h = h * 32'd5 + C3;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * C4;
    h = h ^ (h >> 13);
    h = h * C5;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // apply one command to the predicted filter and return its result
  function automatic filter_result_t apply_filter_cmd(input op_t op, input logic [31:0] k);
    filter_result_t r;
    logic [31:0] s;
    logic [31:0] n;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] hi;
    logic [31:0] pos [HMAX];
    r.ok = 1'b1;
    s = 32'(model_table_size);
    if (s < TS_MIN) s = TS_MIN;
    if (s > DEPTH) s = DEPTH;
    n = 32'(model_num_hashes);
    if (n < 1) n = 1;
    if (n > HMAX) n = HMAX;
    h1 = murmur_mix(k, 32'd0);
    h2 = murmur_mix(k, h1);
    for (int i = 0; i < HMAX; i++) begin
      hi = h1 + i * h2;
      pos[i] = hi % s;
    end
    case (op)
      OP_ADD: begin
        for (int i = 0; i < n; i++)
          if (model_counters[pos[i]] < CMAX) model_counters[pos[i]]++;
        if (model_elements != 31'h7fffffff) model_elements++;
      end
      OP_REMOVE, OP_LOOKUP: begin
        for (int i = 0; i < n; i++)
          if (model_counters[pos[i]] == 0) r.ok = 1'b0;
        if (op == OP_REMOVE && r.ok) begin
          for (int i = 0; i < n; i++)
            if (model_counters[pos[i]] > 0) model_counters[pos[i]]--;
          if (model_elements > 0) model_elements--;
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) model_counters[i] = '0;
        model_elements = '0;
      end
    endcase
    r.count = model_elements;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_cmd(input op_t op, input logic [31:0] k);
    start <= 1'b1;
    cmd   <= op;
    key   <= k;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_filter_cmd(op, k));
    if (op == OP_ADD && added_keys.size() < 64) added_keys.push_back(k);
    @(negedge clk);
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // random bursts with random gaps on the command side
  task automatic paced_cmd(input op_t op, input logic [31:0] k);
    if (burst_left == 0) begin
      pause_cycles($urandom_range(1, 20));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    send_cmd(op, k);
  endtask

  task automatic wait_idle();
    pause_cycles(1);
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TABLE_SIZE) model_table_size = data[12:0];
    else if (addr == ADDR_NUM_HASHES) model_num_hashes = data[4:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] size, input logic [31:0] hashes,
                           input bit clear_after);
    wait_idle();
    write_reg(ADDR_TABLE_SIZE, size);
    write_reg(ADDR_NUM_HASHES, hashes);
    if (clear_after) send_cmd(OP_CLEAR, $urandom);
  endtask

  task automatic test_directed();
    configure(64, 1, 1'b0);
    send_cmd(OP_LOOKUP, 32'h0000_0000);
    send_cmd(OP_REMOVE, 32'h0000_0000);
    send_cmd(OP_ADD, 32'h0000_0000);
    send_cmd(OP_LOOKUP, 32'h0000_0000);
    // counter saturation on a repeated key
    repeat (17) send_cmd(OP_ADD, 32'hffff_ffff);
    send_cmd(OP_REMOVE, 32'h0000_0000);
    send_cmd(OP_ADD, 32'h7fff_ffff);
    send_cmd(OP_ADD, 32'h8000_0000);
    send_cmd(OP_CLEAR, 32'h8000_0000);
    send_cmd(OP_LOOKUP, 32'hffff_ffff);
  endtask

  task automatic test_config_extremes();
    // out of range sizes and counts saturate; size changes without a clear
    configure(0, 0, 1'b0);
    send_cmd(OP_ADD, 32'h1234_5678);
    configure(8191, 31, 1'b0);
    send_cmd(OP_LOOKUP, 32'h1234_5678);
    send_cmd(OP_ADD, 32'h1234_5678);
    configure(63, 21, 1'b0);
    send_cmd(OP_LOOKUP, 32'h1234_5678);
    configure(4096, 20, 1'b1);
    send_cmd(OP_ADD, 32'hdead_beef);
    send_cmd(OP_REMOVE, 32'hdead_beef);
    configure(4097, 7, 1'b0);
    send_cmd(OP_LOOKUP, 32'hdead_beef);
  endtask

  task automatic test_count_floor();
    // two positions per add, one per remove: elements hits zero with counters left
    configure(64, 2, 1'b1);
    repeat (20) send_cmd(OP_ADD, $urandom);
    configure(64, 1, 1'b0);
    repeat (60) send_cmd(OP_REMOVE, $urandom);
  endtask

  task automatic test_random();
    int sent = 0;
    int phase_len;
    int pick;
    logic [31:0] k;
    op_t op;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       configure(64, 1, 1'b1);
        1:       configure(4096, 20, 1'b1);
        2:       configure($urandom_range(0, 8191), $urandom_range(0, 31), $urandom_range(0, 1));
        3:       configure($urandom_range(64, 4096), 4, 1'b0);
        default: configure($urandom_range(64, 512), $urandom_range(1, 6), 1'b1);
      endcase
      if ($urandom_range(0, 1)) added_keys.delete();
      phase_len = (model_num_hashes > 8) ? $urandom_range(20, 50) : $urandom_range(60, 140);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        k = $urandom;
        if (pick < 38) op = OP_ADD;
        else if (pick < 64) op = OP_REMOVE;
        else if (pick < 99) op = OP_LOOKUP;
        else op = OP_CLEAR;
        if ((op == OP_REMOVE || op == OP_LOOKUP) && added_keys.size() != 0
            && $urandom_range(0, 9) < 7)
          k = added_keys[$urandom_range(0, added_keys.size() - 1)];
        paced_cmd(op, k);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    filter_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b element_count=%0d", $time, ok, element_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (ok !== exp_r.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, exp_r.ok, ok);
          errors++;
        end
        if (element_count !== exp_r.count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, exp_r.count,
                   element_count);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) model_counters[i] = '0;
    model_elements   = '0;
    model_table_size = TS_RESET;
    model_num_hashes = NH_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_count_floor();
    test_random();
    wait_idle();
    repeat (300) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
